// ===== rtl/core/tsm_pkg.sv =====
// Shared constants for the triangle side metrics pipeline.
// Holds the fixed result widths and the CORDIC arctangent table in degrees.
// No dependencies.
package tsm_pkg;

  // Fixed result field widths.
  localparam int SUM_W   = 18;
  localparam int SURF_W  = 23;
  localparam int ANGLE_W = 16;

  localparam logic [SURF_W-1:0] SURF_MAX = {SURF_W{1'b1}};

  // The cosine numerator is scaled up by this many bits before the CORDIC.
  localparam int PRESCALE = 24;
  // Fraction bits of the CORDIC angle accumulator, in degrees.
  localparam int DEG_FRAC = 24;
  // Signed width of the angle accumulator.
  localparam int ZW = 34;

  localparam int ATAN_ENTRIES = 24;

  // atan(2^-i) in degrees, 24 fraction bits.
  localparam logic [31:0] ATAN_DEG [ATAN_ENTRIES] = '{
    32'd754974720, 32'd445687602, 32'd235489089, 32'd119537938,
    32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
    32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
    32'd234684,    32'd117342,    32'd58671,     32'd29335,
    32'd14668,     32'd7334,      32'd3667,      32'd1833,
    32'd917,       32'd458,       32'd229,       32'd115
  };

endpackage

// ===== rtl/core/tsm_isqrt.sv =====
// Pipelined integer square root, one root bit resolved per register stage.
// Carries a side payload in step with the radicand. Uses tsm_pkg.
module tsm_isqrt import tsm_pkg::*; #(
  parameter int RES_W = 59,
  parameter int PL_W  = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [2*RES_W-1:0] in_rad,
  input  logic [PL_W-1:0]    in_pl,
  output logic               out_vld,
  output logic [RES_W-1:0]   out_root,
  output logic [PL_W-1:0]    out_pl
);

  localparam int RAD_W = 2 * RES_W;
  localparam int RMW   = RES_W + 2;

  logic             vld_r  [RES_W];
  logic [RMW-1:0]   rem_r  [RES_W];
  logic [RES_W-1:0] root_r [RES_W];
  logic [RAD_W-1:0] rad_r  [RES_W];
  logic [PL_W-1:0]  pl_r   [RES_W];

  for (genvar k = 0; k < RES_W; k++) begin : g_stage
    logic             vld_in;
    logic [RMW-1:0]   rem_in;
    logic [RES_W-1:0] root_in;
    logic [RAD_W-1:0] rad_in;
    logic [PL_W-1:0]  pl_in;
    logic [RMW-1:0]   rem_sh;
    logic [RMW-1:0]   trial;
    logic [RMW-1:0]   rem_nxt;
    logic [RES_W-1:0] root_nxt;

    if (k == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_rad;
      assign pl_in   = in_pl;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign pl_in   = pl_r[k-1];
    end

    // The top two remainder bits are always zero before the shift.
    always_comb begin
      rem_sh = {rem_in[RMW-3:0], rad_in[RAD_W-1:RAD_W-2]};
      trial  = {root_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_in[RES_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_in[RES_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        rad_r[k]  <= rad_in << 2;
        pl_r[k]   <= pl_in;
      end
    end
  end

  assign out_vld  = vld_r[RES_W-1];
  assign out_root = root_r[RES_W-1];
  assign out_pl   = pl_r[RES_W-1];

endmodule

// ===== rtl/core/tsm_cordic.sv =====
// Three-lane pipelined CORDIC in vectoring mode, one rotation per stage.
// Turns (numerator, root) pairs into angles in degrees. Uses tsm_pkg.
module tsm_cordic import tsm_pkg::*; #(
  parameter int ITER  = 16,
  parameter int RES_W = 59,
  parameter int NUM_W = 34,
  parameter int PL_W  = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [RES_W-1:0]      in_root,
  input  logic [2:0][NUM_W-1:0] in_num,
  input  logic [PL_W-1:0]       in_pl,
  output logic                  out_vld,
  output logic [2:0][ZW-1:0]    out_z,
  output logic [PL_W-1:0]       out_pl
);

  localparam int CW = RES_W + 3;

  logic                 vld_r [ITER+1];
  logic [PL_W-1:0]      pl_r  [ITER+1];
  logic signed [CW-1:0] x_r   [ITER+1][3];
  logic signed [CW-1:0] y_r   [ITER+1][3];
  logic signed [ZW-1:0] z_r   [ITER+1][3];

  // Stage zero: a negative numerator is pre-rotated by -90 degrees.
  for (genvar l = 0; l < 3; l++) begin : g_init
    logic [NUM_W-1:0] mag;
    logic [CW-1:0]    mag_sh;
    logic [CW-1:0]    root_ext;

    always_comb begin
      mag      = in_num[l][NUM_W-1] ? (~in_num[l] + 1'b1) : in_num[l];
      mag_sh   = CW'(mag) << PRESCALE;
      root_ext = CW'(in_root);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (in_num[l][NUM_W-1]) begin
          x_r[0][l] <= root_ext;
          y_r[0][l] <= mag_sh;
          z_r[0][l] <= ZW'(90) << DEG_FRAC;
        end else begin
          x_r[0][l] <= mag_sh;
          y_r[0][l] <= root_ext;
          z_r[0][l] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r[0] <= in_pl;
    end
  end

  for (genvar k = 1; k <= ITER; k++) begin : g_iter
    localparam int I = k - 1;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pl_r[k] <= pl_r[k-1];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [ZW-1:0] step;

      always_comb begin
        dx   = y_r[k-1][l] >>> I;
        dy   = x_r[k-1][l] >>> I;
        step = ZW'(ATAN_DEG[I]);
      end

      // Both updates use the values from the start of the rotation.
      always_ff @(posedge clk) begin
        if (en) begin
          if (!y_r[k-1][l][CW-1]) begin
            x_r[k][l] <= x_r[k-1][l] + dx;
            y_r[k][l] <= y_r[k-1][l] - dy;
            z_r[k][l] <= z_r[k-1][l] + step;
          end else begin
            x_r[k][l] <= x_r[k-1][l] - dx;
            y_r[k][l] <= y_r[k-1][l] + dy;
            z_r[k][l] <= z_r[k-1][l] - step;
          end
        end
      end
    end
  end

  assign out_vld = vld_r[ITER];
  assign out_pl  = pl_r[ITER];
  for (genvar l = 0; l < 3; l++) begin : g_out
    assign out_z[l] = z_r[ITER][l];
  end

endmodule

// ===== rtl/core/triangle_side_metrics.sv =====
// Triangle side metrics: existence, equal sides, perimeter, Heron area and
// law-of-cosines angles for unsigned fixed-point sides. Depends on tsm_pkg,
// tsm_isqrt and tsm_cordic.
//
// One triangle is taken per clock cycle and each result leaves in order. The
// pipeline depth is set by the square-root pipeline, which resolves one root
// bit per stage over the widened Heron product, followed by one CORDIC
// rotation per stage for the three angles. A held result stalls the pipeline
// as a whole, but the input stage still takes a transfer while it is empty.
// Perimeter, area and angles read zero when the sides fail the strict triangle
// inequality; the equal-sides flag is reported in every case.
module triangle_side_metrics import tsm_pkg::*; #(
  parameter int SIDE_WIDTH      = 16,
  parameter int FRAC_BITS       = 8,
  parameter int ACOS_ITERATIONS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SIDE_WIDTH-1:0] in_side_a,
  input  logic [SIDE_WIDTH-1:0] in_side_b,
  input  logic [SIDE_WIDTH-1:0] in_side_c,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_valid_triangle,
  output logic                  out_all_sides_equal,
  output logic [SUM_W-1:0]      out_side_sum,
  output logic [SURF_W-1:0]     out_surface,
  output logic [ANGLE_W-1:0]    out_angle_opposite_a,
  output logic [ANGLE_W-1:0]    out_angle_opposite_b,
  output logic [ANGLE_W-1:0]    out_angle_opposite_c
);

  localparam int S      = SIDE_WIDTH;
  localparam int PW     = S + 2;
  localparam int UW     = S + 1;
  localparam int SQW    = 2 * S;
  localparam int NUM_W  = 2 * S + 2;
  localparam int PUW    = PW + UW;
  localparam int VWW    = 2 * UW;
  localparam int PLW    = PUW + UW;
  localparam int PROD_W = PW + 3 * UW;
  localparam int RES_W  = (PROD_W + 2 * PRESCALE + 1) / 2;
  localparam int RAD_W  = 2 * RES_W;
  localparam int SQ_PL  = 2 + PW + 3 * NUM_W;
  localparam int CO_PL  = 2 + PW + SURF_W;
  localparam int SHIFT  = DEG_FRAC - FRAC_BITS;

  logic adv;
  logic en_in;

  // Stage 1: input registers.
  logic         v1_r;
  logic [S-1:0] a1_r, b1_r, c1_r;

  // Stage 2: sums, existence test, first products and squares.
  logic           v2_r, tri2_r, eq2_r;
  logic [PW-1:0]  p2_r;
  logic [PUW-1:0] pu2_r;
  logic [VWW-1:0] vw2_r;
  logic [SQW-1:0] aa2_r, bb2_r, cc2_r;

  logic           tri_nxt;
  logic [PW-1:0]  p_nxt, u_full, v_full, w_full;

  // Stage 3: partial products of the Heron product, cosine numerators.
  logic                  v3_r, tri3_r, eq3_r;
  logic [PW-1:0]         p3_r;
  logic [PLW-1:0]        pl3_r, ph3_r;
  logic [2:0][NUM_W-1:0] num3_r;

  // Stage 4: full Heron product.
  logic                  v4_r, tri4_r, eq4_r;
  logic [PW-1:0]         p4_r;
  logic [PROD_W-1:0]     prod4_r;
  logic [2:0][NUM_W-1:0] num4_r;

  logic [RAD_W-1:0]      sq_rad;
  logic                  sq_vld;
  logic [RES_W-1:0]      sq_root;
  logic [SQ_PL-1:0]      sq_pl;
  logic                  sq_tri, sq_eq;
  logic [PW-1:0]         sq_p;
  logic [2:0][NUM_W-1:0] sq_num;

  logic [RES_W:0]        surf_rnd;
  logic [RES_W:0]        surf_q;
  logic [SURF_W-1:0]     surf;

  logic                  co_vld;
  logic [2:0][ZW-1:0]    co_z;
  logic [CO_PL-1:0]      co_pl;
  logic                  co_tri, co_eq;
  logic [PW-1:0]         co_p;
  logic [SURF_W-1:0]     co_surf;

  logic                      out_valid_r;
  logic                      tri_o_r, eq_o_r;
  logic [SUM_W-1:0]          sum_o_r;
  logic [SURF_W-1:0]         surf_o_r;
  logic [2:0][ANGLE_W-1:0]   ang_o_r;
  logic [2:0][ANGLE_W-1:0]   ang_nxt;

  assign adv      = !out_valid_r || out_ready;
  assign en_in    = adv || !v1_r;
  assign in_ready = en_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en_in) begin
        v1_r <= in_valid;
      end
      if (adv) begin
        v2_r <= v1_r;
        v3_r <= v2_r;
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_in) begin
      a1_r <= in_side_a;
      b1_r <= in_side_b;
      c1_r <= in_side_c;
    end
  end

  always_comb begin
    tri_nxt = (PW'(a1_r) + PW'(b1_r) > PW'(c1_r)) &&
              (PW'(a1_r) + PW'(c1_r) > PW'(b1_r)) &&
              (PW'(b1_r) + PW'(c1_r) > PW'(a1_r));
    p_nxt   = PW'(a1_r) + PW'(b1_r) + PW'(c1_r);
    u_full  = PW'(b1_r) + PW'(c1_r) - PW'(a1_r);
    v_full  = PW'(a1_r) + PW'(c1_r) - PW'(b1_r);
    w_full  = PW'(a1_r) + PW'(b1_r) - PW'(c1_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tri2_r <= tri_nxt;
      eq2_r  <= (a1_r == b1_r) && (b1_r == c1_r);
      p2_r   <= p_nxt;
      pu2_r  <= PUW'(p_nxt) * PUW'(u_full[UW-1:0]);
      vw2_r  <= VWW'(v_full[UW-1:0]) * VWW'(w_full[UW-1:0]);
      aa2_r  <= SQW'(a1_r) * SQW'(a1_r);
      bb2_r  <= SQW'(b1_r) * SQW'(b1_r);
      cc2_r  <= SQW'(c1_r) * SQW'(c1_r);
    end
  end

  // The numerators wrap modulo 2^NUM_W, which is their two's complement form.
  always_ff @(posedge clk) begin
    if (adv) begin
      tri3_r    <= tri2_r;
      eq3_r     <= eq2_r;
      p3_r      <= p2_r;
      pl3_r     <= PLW'(pu2_r) * PLW'(vw2_r[UW-1:0]);
      ph3_r     <= PLW'(pu2_r) * PLW'(vw2_r[VWW-1:UW]);
      num3_r[0] <= NUM_W'(bb2_r) + NUM_W'(cc2_r) - NUM_W'(aa2_r);
      num3_r[1] <= NUM_W'(aa2_r) + NUM_W'(cc2_r) - NUM_W'(bb2_r);
      num3_r[2] <= NUM_W'(aa2_r) + NUM_W'(bb2_r) - NUM_W'(cc2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tri4_r  <= tri3_r;
      eq4_r   <= eq3_r;
      p4_r    <= p3_r;
      prod4_r <= PROD_W'(pl3_r) + (PROD_W'(ph3_r) << UW);
      num4_r  <= num3_r;
    end
  end

  assign sq_rad = RAD_W'(prod4_r) << (2 * PRESCALE);

  tsm_isqrt #(
    .RES_W (RES_W),
    .PL_W  (SQ_PL)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (v4_r),
    .in_rad   (sq_rad),
    .in_pl    ({tri4_r, eq4_r, p4_r, num4_r}),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_pl   (sq_pl)
  );

  assign {sq_tri, sq_eq, sq_p, sq_num} = sq_pl;

  // Area is the prescaled root over 2^(FRAC_BITS+PRESCALE+2), rounded half up and saturated.
  always_comb begin
    surf_rnd = (RES_W+1)'(sq_root) + ((RES_W+1)'(1) << (FRAC_BITS + PRESCALE + 1));
    surf_q   = surf_rnd >> (FRAC_BITS + PRESCALE + 2);
    surf     = (surf_q > (RES_W+1)'(SURF_MAX)) ? SURF_MAX : SURF_W'(surf_q);
  end

  tsm_cordic #(
    .ITER  (ACOS_ITERATIONS),
    .RES_W (RES_W),
    .NUM_W (NUM_W),
    .PL_W  (CO_PL)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (sq_vld),
    .in_root (sq_root),
    .in_num  (sq_num),
    .in_pl   ({sq_tri, sq_eq, sq_p, surf}),
    .out_vld (co_vld),
    .out_z   (co_z),
    .out_pl  (co_pl)
  );

  assign {co_tri, co_eq, co_p, co_surf} = co_pl;

  for (genvar l = 0; l < 3; l++) begin : g_angle
    logic [ZW-1:0] zr;
    logic [ZW-1:0] zs;

    always_comb begin
      zr = co_z[l] + (ZW'(1) << (SHIFT - 1));
      zs = zr >> SHIFT;
      if (zr[ZW-1] || !co_tri) begin
        ang_nxt[l] = '0;
      end else if (zs > (ZW'(180) << FRAC_BITS)) begin
        ang_nxt[l] = ANGLE_W'(ZW'(180) << FRAC_BITS);
      end else begin
        ang_nxt[l] = ANGLE_W'(zs);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= co_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tri_o_r  <= co_tri;
      eq_o_r   <= co_eq;
      sum_o_r  <= co_tri ? SUM_W'(co_p) : '0;
      surf_o_r <= co_tri ? co_surf : '0;
      ang_o_r  <= ang_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_valid_triangle   = tri_o_r;
  assign out_all_sides_equal  = eq_o_r;
  assign out_side_sum         = sum_o_r;
  assign out_surface          = surf_o_r;
  assign out_angle_opposite_a = ang_o_r[0];
  assign out_angle_opposite_b = ang_o_r[1];
  assign out_angle_opposite_c = ang_o_r[2];

endmodule

// ===== tb/tb_triangle_side_metrics.sv =====
// Self-checking testbench for triangle_side_metrics: random valid/ready traffic on both sides.
// The scoreboard predicts existence, perimeter, Heron area and CORDIC angles for each transfer.
// Depends on tsm_pkg and the triangle_side_metrics RTL.
module tb_triangle_side_metrics;
  timeunit 1ns;
  timeprecision 1ps;
  import tsm_pkg::*;

  localparam int SW = 16;
  localparam int FB = 8;
  localparam int ITERS = 16;
  localparam int LATENCY = 2 * SW + ITERS + 33;
  localparam int N_RANDOM = 1200;

  typedef struct packed {
    logic                 exists;
    logic                 equal;
    logic [SUM_W-1:0]     perim;
    logic [SURF_W-1:0]    area;
    logic [ANGLE_W-1:0]   ang_a;
    logic [ANGLE_W-1:0]   ang_b;
    logic [ANGLE_W-1:0]   ang_c;
  } metrics_t;

  // Angle from the cosine numerator and the Heron root by CORDIC vectoring.
  function automatic logic [ANGLE_W-1:0] cordic_deg(longint num, logic [63:0] root);
    longint mag, x, y, z, dx, dy;
    mag = (num < 0) ? -num : num;
    mag = mag <<< PRESCALE;
    if (num < 0) begin
      x = longint'(root); y = mag; z = longint'(90) <<< DEG_FRAC;
    end else begin
      x = mag; y = longint'(root); z = 0;
    end
    for (int i = 0; i < ITERS && i < ATAN_ENTRIES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(ATAN_DEG[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_DEG[i]);
      end
    end
    z += longint'(1) <<< (DEG_FRAC - FB - 1);
    if (z < 0) return '0;
    z = z >>> (DEG_FRAC - FB);
    if (z > (longint'(180) <<< FB)) z = longint'(180) <<< FB;
    return z[ANGLE_W-1:0];
  endfunction

  function automatic metrics_t triangle_metrics(logic [SW-1:0] a, logic [SW-1:0] b,
                                                logic [SW-1:0] c);
    metrics_t m;
    longint la, lb, lc;
    logic [127:0] pu, vw, scaled, sq;
    logic [63:0] root, cand, surf;
    la = a; lb = b; lc = c;
    m = '0;
    m.exists = (la + lb > lc) && (la + lc > lb) && (lb + lc > la);
    m.equal = (a == b) && (b == c);
    if (m.exists) begin
      pu = 128'((la + lb + lc) * (lb + lc - la));
      vw = 128'((la + lc - lb) * (la + lb - lc));
      scaled = (pu * vw) << (2 * PRESCALE);
      root = '0;
      for (int i = 63; i >= 0; i--) begin
        cand = root | (64'd1 << i);
        sq = 128'(cand) * 128'(cand);
        if (sq <= scaled) root = cand;
      end
      surf = (root + (64'd1 << (FB + PRESCALE + 1))) >> (FB + PRESCALE + 2);
      if (surf > 64'(SURF_MAX)) surf = 64'(SURF_MAX);
      m.perim = SUM_W'(la + lb + lc);
      m.area = surf[SURF_W-1:0];
      m.ang_a = cordic_deg(lb * lb + lc * lc - la * la, root);
      m.ang_b = cordic_deg(la * la + lc * lc - lb * lb, root);
      m.ang_c = cordic_deg(la * la + lb * lb - lc * lc, root);
    end
    return m;
  endfunction

  class metrics_scoreboard;
    metrics_t pending[$];
    int errors = 0;

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void note_triangle(logic [SW-1:0] a, logic [SW-1:0] b, logic [SW-1:0] c);
      pending.insert(pending.size(), triangle_metrics(a, b, c));
    endfunction

    task check_result(metrics_t got);
      metrics_t exp;
      if (pending.size() == 0) begin
        report("result with no triangle outstanding");
        return;
      end
      exp = pending.pop_front();
      if (got.exists !== exp.exists)
        report($sformatf("valid_triangle %0d exp %0d", got.exists, exp.exists));
      if (got.equal !== exp.equal)
        report($sformatf("all_sides_equal %0d exp %0d", got.equal, exp.equal));
      if (got.perim !== exp.perim)
        report($sformatf("side_sum %0d exp %0d", got.perim, exp.perim));
      if (got.area !== exp.area)
        report($sformatf("surface %0d exp %0d", got.area, exp.area));
      if (got.ang_a !== exp.ang_a)
        report($sformatf("angle_opposite_a %0d exp %0d", got.ang_a, exp.ang_a));
      if (got.ang_b !== exp.ang_b)
        report($sformatf("angle_opposite_b %0d exp %0d", got.ang_b, exp.ang_b));
      if (got.ang_c !== exp.ang_c)
        report($sformatf("angle_opposite_c %0d exp %0d", got.ang_c, exp.ang_c));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SW-1:0] in_side_a = '0, in_side_b = '0, in_side_c = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_valid_triangle, out_all_sides_equal;
  logic [SUM_W-1:0] out_side_sum;
  logic [SURF_W-1:0] out_surface;
  logic [ANGLE_W-1:0] out_angle_opposite_a, out_angle_opposite_b, out_angle_opposite_c;

  metrics_scoreboard sb = new();
  int sent = 0;
  bit stim_done = 1'b0;

  triangle_side_metrics i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_side_a(in_side_a), .in_side_b(in_side_b), .in_side_c(in_side_c),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_valid_triangle(out_valid_triangle), .out_all_sides_equal(out_all_sides_equal),
    .out_side_sum(out_side_sum), .out_surface(out_surface),
    .out_angle_opposite_a(out_angle_opposite_a),
    .out_angle_opposite_b(out_angle_opposite_b),
    .out_angle_opposite_c(out_angle_opposite_c)
  );

  always #6 clk = ~clk;

  // Transfers are recorded from the values seen just before the edge updates them.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_triangle(in_side_a, in_side_b, in_side_c);
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_valid_triangle, out_all_sides_equal, out_side_sum, out_surface,
                       out_angle_opposite_a, out_angle_opposite_b, out_angle_opposite_c});
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task send_triangle(logic [SW-1:0] a, logic [SW-1:0] b, logic [SW-1:0] c);
    bit calm;
    calm = (sent >= 400) && (sent < 700);
    if (!calm) begin
      while ($urandom_range(99) < 20) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_side_a <= a;
    in_side_b <= b;
    in_side_c <= c;
    do @(posedge clk); while (!in_ready);
    sent++;
    @(negedge clk);
  endtask

  task send_random();
    logic [SW-1:0] a, b, c;
    int lo, hi;
    case ($urandom_range(9))
      0, 1: begin
        a = SW'($urandom); b = SW'($urandom); c = SW'($urandom);
      end
      2: begin
        a = SW'($urandom_range(16)); b = SW'($urandom_range(16));
        c = SW'($urandom_range(16));
      end
      3: begin
        // Degenerate: one side equals the sum of the others.
        a = SW'($urandom_range(32767)); b = SW'($urandom_range(32767)); c = a + b;
      end
      4: begin
        a = SW'($urandom); b = a; c = a;
      end
      default: begin
        // Third side strictly between difference and sum, or a when that range is empty.
        a = SW'($urandom); b = SW'($urandom);
        lo = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
        hi = int'(a) + int'(b);
        if (hi > 65535) hi = 65535;
        c = (hi > lo + 1) ? SW'($urandom_range(hi - 1, lo + 1)) : a;
      end
    endcase
    case ($urandom_range(2))
      0: send_triangle(a, b, c);
      1: send_triangle(c, a, b);
      default: send_triangle(b, c, a);
    endcase
  endtask

  // Receiver, with one long hold-off so the pipeline fills and backs up.
  initial begin
    int hold;
    bit held_once;
    hold = 0;
    held_once = 0;
    forever begin
      @(negedge clk);
      if (!held_once && sent >= 300) begin
        held_once = 1;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (sent >= 400 && sent < 700) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 20);
      end
    end
  end

  initial begin
    int waited;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_triangle(16'd0, 16'd0, 16'd0);
    send_triangle(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_triangle(16'd1, 16'd1, 16'd1);
    send_triangle(16'd256, 16'd256, 16'd256);
    send_triangle(16'd768, 16'd1024, 16'd1280);
    send_triangle(16'd1280, 16'd768, 16'd1024);
    send_triangle(16'd1024, 16'd1280, 16'd768);
    send_triangle(16'd100, 16'd200, 16'd300);
    send_triangle(16'd300, 16'd100, 16'd200);
    send_triangle(16'd1, 16'd1, 16'hFFFF);
    send_triangle(16'hFFFF, 16'hFFFF, 16'd1);
    send_triangle(16'hFFFF, 16'd1, 16'hFFFF);
    send_triangle(16'd1, 16'hFFFF, 16'hFFFF);
    send_triangle(16'hFFFF, 16'h8000, 16'h8000);
    send_triangle(16'hFFFF, 16'hFFFE, 16'd2);
    send_triangle(16'd0, 16'd5, 16'd5);
    send_triangle(16'd500, 16'd400, 16'd890);
    send_triangle(16'h5555, 16'hAAAA, 16'hAAAA);
    send_triangle(16'hAAAA, 16'h5555, 16'h5555);
    send_triangle(16'd2, 16'd3, 16'd4);
    for (int n = 0; n < N_RANDOM; n++) send_random();
    in_valid <= 1'b0;
    stim_done = 1'b1;
    waited = 0;
    while (sb.pending.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * LATENCY) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_triangle_side_metrics OK");
    end else begin
      $display("tb_triangle_side_metrics NOT OK");
    end
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("tb_triangle_side_metrics NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/tsm_pkg.sv
rtl/core/tsm_isqrt.sv
rtl/core/tsm_cordic.sv
rtl/core/triangle_side_metrics.sv
tb/tb_triangle_side_metrics.sv
